@@ sv/rgbf_pkg.sv @@
`default_nettype none

package rgbf_pkg;

  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CH_W    = $clog2(NUM_CH);
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned SAT_W   = 12;
  localparam int unsigned PROD_W  = TIME_W + CHAN_W;
  localparam int unsigned QBIT_W  = $clog2(CHAN_W);

  localparam logic [CHAN_W-1:0] LEVEL_MAX = 8'd100;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 16'd4095;

  localparam logic [CH_W-1:0] LAST_CH_FADE = 2'd3;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_RGB   = 3'd1,
    REQ_SET_LEVEL = 3'd2,
    REQ_FADE_TO   = 3'd3,
    REQ_FADE_STOP = 3'd4,
    REQ_SET_DUTY  = 3'd5,
    REQ_OFF       = 3'd6
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              mul;
    logic              div_step;
    logic              store;
    logic              emit;
    logic [CH_W-1:0]   ch;
    logic [QBIT_W-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic go_emit;
    logic go_calc;
    logic last_ch;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ sv/rgb_fade_controller.sv @@
`default_nettype none

// Channel   Handshake               Payload
// request   req_valid / req_stall   req_type, now_ms, red/green/blue/level_in,
//                                   fade_length_ms, duty_red/green/blue
// result    res_valid / res_stall   red/green/blue/level_out, fade_active
// config    cfg_valid / cfg_ready   cfg_data (enabled)
//
// One request at a time. Set, level, duty and off requests go through ST_EMIT to
// the output register; a fade tick mid-fade runs ST_MUL, ST_DIV and ST_STORE for
// each of the 4 channels: one multiply, 8 restoring divide steps and one
// write-back in the shared divider. ST_EMIT waits while a result is held.
// Synchronous reset: enabled = 1, color and level 0, no fade, no result.
// The output register lets a new request in while a result waits on res_stall.

module rgb_fade_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] now_ms,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [7:0]  level_in,
  input  wire logic [31:0] fade_length_ms,
  input  wire logic [15:0] duty_red,
  input  wire logic [15:0] duty_green,
  input  wire logic [15:0] duty_blue,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic [7:0]       level_out,
  output logic             fade_active
);

  rgbf_pkg::cmd_t    cmd;
  rgbf_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  rgbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rgbf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .now_ms         (now_ms),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .level_in       (level_in),
    .fade_length_ms (fade_length_ms),
    .duty_red       (duty_red),
    .duty_green     (duty_green),
    .duty_blue      (duty_blue),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .level_out      (level_out),
    .fade_active    (fade_active)
  );

endmodule

`default_nettype wire

@@ sv/rgbf_ctrl.sv @@
`default_nettype none

module rgbf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire rgbf_pkg::status_t stat,
  output rgbf_pkg::cmd_t        cmd
);

  rgbf_pkg::state_t                   state, state_next;
  logic [rgbf_pkg::CH_W-1:0]          ch, ch_next;
  logic [rgbf_pkg::QBIT_W-1:0]        bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rgbf_pkg::ST_IDLE;
      ch      <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      ch      <= ch_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    bit_idx_next = bit_idx;
    req_stall    = 1'b1;
    cmd          = '0;
    cmd.ch       = ch;
    cmd.bit_idx  = bit_idx;
    case (state)
      rgbf_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (stat.go_emit) begin
            state_next = rgbf_pkg::ST_EMIT;
          end else if (stat.go_calc) begin
            state_next = rgbf_pkg::ST_MUL;
            ch_next    = '0;
          end
        end
      end
      rgbf_pkg::ST_MUL: begin
        cmd.mul      = 1'b1;
        bit_idx_next = rgbf_pkg::QBIT_W'(rgbf_pkg::CHAN_W - 1);
        state_next   = rgbf_pkg::ST_DIV;
      end
      rgbf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_idx == '0) begin
          state_next = rgbf_pkg::ST_STORE;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
      rgbf_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.last_ch) begin
          state_next = rgbf_pkg::ST_EMIT;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = rgbf_pkg::ST_MUL;
        end
      end
      rgbf_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = rgbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rgbf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/rgbf_datapath.sv @@
`default_nettype none

module rgbf_datapath (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rgbf_pkg::cmd_t cmd,
  output rgbf_pkg::status_t   stat,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_data,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] now_ms,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [7:0]  level_in,
  input  wire logic [31:0] fade_length_ms,
  input  wire logic [15:0] duty_red,
  input  wire logic [15:0] duty_green,
  input  wire logic [15:0] duty_blue,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic [7:0]       level_out,
  output logic             fade_active
);

  localparam int unsigned CW = rgbf_pkg::CHAN_W;
  localparam int unsigned TW = rgbf_pkg::TIME_W;
  localparam int unsigned PW = rgbf_pkg::PROD_W;
  localparam int unsigned SW = rgbf_pkg::SAT_W;
  localparam int unsigned YW = SW + CW;

  logic          enabled;
  logic          fading;
  logic [CW-1:0] cur_c  [rgbf_pkg::NUM_CH];
  logic [CW-1:0] from_c [rgbf_pkg::NUM_CH];
  logic [CW-1:0] to_c   [rgbf_pkg::NUM_CH];
  logic [TW-1:0] span;
  logic [TW-1:0] origin;
  logic [TW-1:0] el;
  logic [PW-1:0] rem;
  logic [CW-1:0] quo;

  logic [TW-1:0] el_in;
  logic          tick_end;
  logic          is_tick, is_emit_req, is_duty_req;
  logic [CW-1:0] a_ch, b_ch, mag;
  logic          up;
  logic [PW-1:0] dv_sh;
  logic          take;
  logic [CW-1:0] ch_val;

  // saturate to 4095, then d*255/4095; dividing by 2^12-1 as
  // (y + y/4096 + 1)/4096 is exact for y below 2^24 - 1
  function automatic logic [CW-1:0] duty_to8(input logic [rgbf_pkg::DUTY_W-1:0] d);
    logic [SW-1:0] s;
    logic [YW-1:0] y;
    logic [YW-1:0] q;
    s = (d > rgbf_pkg::DUTY_MAX) ? rgbf_pkg::DUTY_MAX[SW-1:0] : d[SW-1:0];
    y = {{CW{1'b0}}, s} * {{SW{1'b0}}, rgbf_pkg::CHAN_MAX};
    q = y + {{SW{1'b0}}, y[YW-1:SW]} + YW'(1);
    return q[YW-1:SW];
  endfunction

  // request decode for the controller
  assign el_in       = now_ms - origin;
  assign tick_end    = (el_in >= span);
  assign is_tick     = (req_type == rgbf_pkg::REQ_TICK) && fading;
  assign is_duty_req = (req_type == rgbf_pkg::REQ_SET_DUTY);
  assign is_emit_req = (req_type == rgbf_pkg::REQ_SET_RGB) ||
                       (req_type == rgbf_pkg::REQ_SET_LEVEL) ||
                       (req_type == rgbf_pkg::REQ_OFF);

  assign stat.go_emit  = enabled && (is_emit_req || is_duty_req || (is_tick && tick_end));
  assign stat.go_calc  = enabled && is_tick && !tick_end;
  assign stat.last_ch  = (cmd.ch == rgbf_pkg::LAST_CH_FADE);
  assign stat.out_free = !res_valid || !res_stall;

  // per-channel operands: lerp uses el*|b-a|/span
  assign a_ch = from_c[cmd.ch];
  assign b_ch = to_c[cmd.ch];
  assign up   = (b_ch >= a_ch);
  assign mag  = up ? (b_ch - a_ch) : (a_ch - b_ch);

  assign dv_sh = {{(PW-TW){1'b0}}, span} << cmd.bit_idx;
  assign take  = (rem >= dv_sh);

  // quotient stays below 256 since el < span
  assign ch_val = up ? (a_ch + quo) : (a_ch - quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b1;
      fading    <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
        cur_c[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        enabled <= cfg_data;
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.store) begin
        cur_c[cmd.ch] <= ch_val;
      end
      if (cmd.accept && enabled) begin
        case (req_type)
          rgbf_pkg::REQ_TICK: begin
            if (fading && tick_end) begin
              for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
                cur_c[i] <= to_c[i];
              end
              fading <= 1'b0;
            end
          end
          rgbf_pkg::REQ_SET_RGB: begin
            cur_c[0] <= red_in;
            cur_c[1] <= green_in;
            cur_c[2] <= blue_in;
          end
          rgbf_pkg::REQ_SET_LEVEL: begin
            cur_c[3] <= (level_in > rgbf_pkg::LEVEL_MAX) ? rgbf_pkg::LEVEL_MAX : level_in;
          end
          rgbf_pkg::REQ_FADE_TO: begin
            fading <= 1'b1;
          end
          rgbf_pkg::REQ_FADE_STOP: begin
            fading <= 1'b0;
          end
          rgbf_pkg::REQ_SET_DUTY: begin
            cur_c[0] <= duty_to8(duty_red);
            cur_c[1] <= duty_to8(duty_green);
            cur_c[2] <= duty_to8(duty_blue);
            cur_c[3] <= rgbf_pkg::LEVEL_MAX;
          end
          rgbf_pkg::REQ_OFF: begin
            fading   <= 1'b0;
            cur_c[3] <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // fade endpoints, operands, divider and output data: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      el <= el_in;
      if (enabled && (req_type == rgbf_pkg::REQ_FADE_TO)) begin
        for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
          from_c[i] <= cur_c[i];
        end
        to_c[0] <= red_in;
        to_c[1] <= green_in;
        to_c[2] <= blue_in;
        to_c[3] <= level_in;
        span    <= fade_length_ms;
        origin  <= now_ms;
      end
    end
    if (cmd.mul) begin
      rem <= {{(PW-TW){1'b0}}, el} * {{(PW-CW){1'b0}}, mag};
      quo <= '0;
    end else if (cmd.div_step && take) begin
      rem              <= rem - dv_sh;
      quo[cmd.bit_idx] <= 1'b1;
    end
    if (cmd.emit) begin
      red_out     <= cur_c[0];
      green_out   <= cur_c[1];
      blue_out    <= cur_c[2];
      level_out   <= cur_c[3];
      fade_active <= fading;
    end
  end

endmodule

`default_nettype wire
